@@ rtl/core/dbrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA buffer ring scheduler package
// Shared constants, codes and types for the buffer slot ring scheduler.
// ----------------------------------------------------------------------------
package dbrs_pkg;

  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned OUT_SLOT_W = 3;
  localparam int unsigned BYTES_W    = 17;
  localparam int unsigned IRQ_W      = 2;

  localparam logic [BYTES_W-1:0] SLOT_BYTES_MAX = BYTES_W'(124 * 1024);
  localparam int unsigned IRQ_DONE_IDX = 1;
  localparam int unsigned IRQ_ERR_IDX  = 0;

  typedef logic [SLOT_W-1:0]  slot_ptr_t;
  typedef logic [BYTES_W-1:0] bytes_t;

  typedef enum logic {
    REQ_SUBMIT = 1'b0,
    REQ_IRQ    = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_STARTED  = 3'd1,
    ST_ZERO     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOT_OURS = 3'd4,
    ST_ADVANCED = 3'd5,
    ST_SPURIOUS = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EXEC = 2'd1,
    CS_OUT  = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic capture;  // register the incoming transaction
    logic exec;     // update the ring and load the result register
  } ctrl_cmd_t;

  localparam slot_ptr_t SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  function automatic slot_ptr_t slot_inc(input slot_ptr_t p);
    slot_ptr_t r;
    if (p == SLOT_LAST) begin
      r = '0;
    end else begin
      r = p + slot_ptr_t'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/dbrs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA buffer ring scheduler controller
// Sequences one transaction at a time: capture, execute, present the result.
// ----------------------------------------------------------------------------
module dbrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dbrs_pkg::ctrl_cmd_t cmd_o
);
  import dbrs_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        state_d = CS_OUT;
      end
      CS_OUT: begin
        if (!out_stall_i) begin
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      CS_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.exec)
    else $error("Captured transaction was not executed in the next cycle.");

  a_exec_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("Executed transaction did not present a result.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o || cmd_o.exec) |-> in_stall_o)
    else $error("Input accepted while a transaction was still in flight.");

endmodule

@@ rtl/core/dbrs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA buffer ring scheduler datapath
// Holds the ring pointers, slot flags and byte counts, and the result register.
// ----------------------------------------------------------------------------
module dbrs_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dbrs_pkg::ctrl_cmd_t                    cmd_i,
  input  logic                                   req_type_i,
  input  logic [dbrs_pkg::BYTES_W-1:0]           byte_count_i,
  input  logic [dbrs_pkg::IRQ_W-1:0]             irq_status_i,
  output logic [2:0]                             status_o,
  output logic                                   dma_kick_o,
  output logic [dbrs_pkg::OUT_SLOT_W-1:0]        start_slot_o,
  output logic [dbrs_pkg::BYTES_W-1:0]           start_bytes_o,
  output logic [dbrs_pkg::OUT_SLOT_W-1:0]        next_fill_slot_o,
  output logic                                   device_error_o
);
  import dbrs_pkg::*;

  // Captured transaction.
  req_type_e        req_q;
  bytes_t           bytes_q;
  logic [IRQ_W-1:0] irq_q;

  // Ring state.
  slot_ptr_t              fill_q, fill_d;
  slot_ptr_t              drain_q, drain_d;
  logic [NUM_SLOTS-1:0]   slot_full_q;
  bytes_t                 slot_bytes_q [NUM_SLOTS];

  // Result register.
  status_e   status_q, status_d;
  logic      start_q, start_d;
  slot_ptr_t sslot_q, sslot_d;
  bytes_t    sbytes_q, sbytes_d;
  slot_ptr_t nfill_q;
  logic      err_q, err_d;

  bytes_t    sat_bytes;
  slot_ptr_t fill_inc, drain_inc;
  logic      ring_eq;
  logic      set_fill, clr_drain;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_e'(req_type_i);
      bytes_q <= byte_count_i;
      irq_q   <= irq_status_i;
    end
  end

  assign sat_bytes = (bytes_q > SLOT_BYTES_MAX) ? SLOT_BYTES_MAX : bytes_q;
  assign fill_inc  = slot_inc(fill_q);
  assign drain_inc = slot_inc(drain_q);
  assign ring_eq   = (fill_q == drain_q);

  always_comb begin
    fill_d    = fill_q;
    drain_d   = drain_q;
    status_d  = ST_NOT_OURS;
    start_d   = 1'b0;
    sslot_d   = '0;
    sbytes_d  = '0;
    err_d     = 1'b0;
    set_fill  = 1'b0;
    clr_drain = 1'b0;
    priority if (req_q == REQ_SUBMIT) begin
      if (sat_bytes == '0) begin
        status_d = ST_ZERO;
      end else if (ring_eq && slot_full_q[fill_q]) begin
        status_d = ST_FULL;
      end else begin
        set_fill = 1'b1;
        fill_d   = fill_inc;
        if (ring_eq) begin
          // Empty ring: the engine is idle, so issue this transfer at once.
          start_d  = 1'b1;
          sslot_d  = fill_q;
          sbytes_d = sat_bytes;
          status_d = ST_STARTED;
        end else begin
          status_d = ST_QUEUED;
        end
      end
    end else if (!irq_q[IRQ_DONE_IDX]) begin
      status_d = ST_NOT_OURS;
    end else begin
      err_d = irq_q[IRQ_ERR_IDX];
      if (ring_eq && !slot_full_q[fill_q]) begin
        status_d = ST_SPURIOUS;
      end else begin
        clr_drain = 1'b1;
        drain_d   = drain_inc;
        status_d  = ST_ADVANCED;
        // A full ring always has a next slot; otherwise one is queued unless
        // the drain pointer has caught up with the fill pointer.
        if (ring_eq || (fill_q != drain_inc)) begin
          start_d  = 1'b1;
          sslot_d  = drain_inc;
          sbytes_d = slot_bytes_q[drain_inc];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      drain_q     <= '0;
      slot_full_q <= '0;
    end else if (cmd_i.exec) begin
      fill_q  <= fill_d;
      drain_q <= drain_d;
      if (set_fill) begin
        slot_full_q[fill_q] <= 1'b1;
      end
      if (clr_drain) begin
        slot_full_q[drain_q] <= 1'b0;
      end
    end
  end

  // Byte counts are only read from slots that have been filled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && set_fill) begin
      slot_bytes_q[fill_q] <= sat_bytes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      start_q  <= start_d;
      sslot_q  <= sslot_d;
      sbytes_q <= sbytes_d;
      nfill_q  <= fill_d;
      err_q    <= err_d;
    end
  end

  assign status_o         = status_q;
  assign dma_kick_o       = start_q;
  assign start_slot_o     = OUT_SLOT_W'(sslot_q);
  assign start_bytes_o    = sbytes_q;
  assign next_fill_slot_o = OUT_SLOT_W'(nfill_q);
  assign device_error_o   = err_q;

  a_drain_slot_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != drain_q) |-> slot_full_q[drain_q])
    else $error("Ring holds queued slots but the drain slot is not full.");

  a_fill_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_full_q[fill_q] |-> (fill_q == drain_q))
    else $error("Fill slot is full although the ring is not full.");

  a_start_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (!start_q || status_q == ST_STARTED || status_q == ST_ADVANCED))
    else $error("Transfer issued with a status that does not start one.");

endmodule

@@ rtl/core/dma_buffer_ring_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA buffer ring scheduler
// Ring of buffer slots that queues submitted transfers and issues them to the
// DMA engine in order as completion interrupts arrive.
// ----------------------------------------------------------------------------
// Each transaction passes through capture, execute and output: the accepting
// edge captures it, the following cycle updates the ring and loads the result
// register, and the result is valid from the edge after that until it is
// taken, staying valid for as long as the result is stalled; the next
// transaction is accepted in the cycle after the result is taken, so no new
// transaction is accepted before the last result is taken. The controller
// handles one transaction at a time, and the ring pointers, slot flags and
// slot byte counts in the datapath are updated in the execute state.
// Submits with a zero count are ignored, counts above 124 KiB are saturated,
// and a full ring rejects a submit rather than waiting. Transfers are named
// by slot index.
module dma_buffer_ring_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [dbrs_pkg::BYTES_W-1:0]    byte_count_i,
  input  logic [dbrs_pkg::IRQ_W-1:0]      irq_status_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic                            dma_kick_o,
  output logic [dbrs_pkg::OUT_SLOT_W-1:0] start_slot_o,
  output logic [dbrs_pkg::BYTES_W-1:0]    start_bytes_o,
  output logic [dbrs_pkg::OUT_SLOT_W-1:0] next_fill_slot_o,
  output logic                            device_error_o
);
  import dbrs_pkg::*;

  ctrl_cmd_t cmd;

  dbrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  dbrs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .req_type_i       (req_type_i),
    .byte_count_i     (byte_count_i),
    .irq_status_i     (irq_status_i),
    .status_o         (status_o),
    .dma_kick_o       (dma_kick_o),
    .start_slot_o     (start_slot_o),
    .start_bytes_o    (start_bytes_o),
    .next_fill_slot_o (next_fill_slot_o),
    .device_error_o   (device_error_o)
  );

endmodule
